@@ src/gripgsm_pkg.sv @@
// gripgsm_pkg: shared types, codes and helpers for the gripper grasp state machine
// used by gripper_grasp_state_machine and gripgsm_checker; depends on nothing
package gripgsm_pkg;

	// input operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_OPEN  = 2'd1;
	localparam op_t OP_CLOSE = 2'd2;

	// mode codes as seen on the result port
	typedef logic [1:0] mode_code_t;
	localparam mode_code_t MODE_CODE_OPEN    = 2'd0;
	localparam mode_code_t MODE_CODE_CLOSING = 2'd1;
	localparam mode_code_t MODE_CODE_HOLD    = 2'd2;
	localparam mode_code_t MODE_CODE_FAILED  = 2'd3;

	// internal one-hot mode register
	typedef enum logic [3:0] {
		MODE_OPEN    = 4'b0001,
		MODE_CLOSING = 4'b0010,
		MODE_HOLD    = 4'b0100,
		MODE_FAILED  = 4'b1000
	} mode_t;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OPEN_POSITION      = 3'd0;
	localparam cfg_idx_t CFG_OPEN_STEP          = 3'd1;
	localparam cfg_idx_t CFG_CLOSE_POSITION     = 3'd2;
	localparam cfg_idx_t CFG_CLOSE_STEP         = 3'd3;
	localparam cfg_idx_t CFG_OPEN_DRIVE_TORQUE  = 3'd4;
	localparam cfg_idx_t CFG_CLOSE_DRIVE_TORQUE = 3'd5;
	localparam cfg_idx_t CFG_HOLD_DRIVE_TORQUE  = 3'd6;
	localparam cfg_idx_t CFG_CONTACT_TORQUE     = 3'd7;

	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = 12;
	localparam int THRESH_W   = 15;
	localparam int COUNT_W    = 3;

	// fixed margins: 0.02 rad and 0.0087 rad in Q3.12, hold press step
	localparam logic signed [16:0] IN_PLACE_MARGIN = 17'sd82;
	localparam logic signed [16:0] LIMIT_MARGIN    = 17'sd36;
	localparam logic signed [16:0] HOLD_PRESS      = 17'sd41;
	localparam logic [COUNT_W-1:0] CONTACT_TICKS   = 3'd5;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = 3'd7;

	// reset values of the configuration registers
	localparam logic signed [15:0] RST_OPEN_POSITION      = 16'sd6434;
	localparam logic [STEP_W-1:0]  RST_OPEN_STEP          = 12'd205;
	localparam logic signed [15:0] RST_CLOSE_POSITION     = -16'sd2048;
	localparam logic [STEP_W-1:0]  RST_CLOSE_STEP         = 12'd205;
	localparam logic signed [15:0] RST_OPEN_DRIVE_TORQUE  = 16'sd256;
	localparam logic signed [15:0] RST_CLOSE_DRIVE_TORQUE = -16'sd256;
	localparam logic signed [15:0] RST_HOLD_DRIVE_TORQUE  = -16'sd128;
	localparam logic [THRESH_W-1:0] RST_CONTACT_TORQUE    = 15'd128;

	// clamp a 17-bit signed sum to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v[16] != v[15]) begin
			sat16 = v[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	function automatic mode_code_t mode_code(input mode_t m);
		case (m)
			MODE_OPEN:    mode_code = MODE_CODE_OPEN;
			MODE_CLOSING: mode_code = MODE_CODE_CLOSING;
			MODE_HOLD:    mode_code = MODE_CODE_HOLD;
			MODE_FAILED:  mode_code = MODE_CODE_FAILED;
			default:      mode_code = MODE_CODE_OPEN;
		endcase
	endfunction

endpackage

@@ src/gripper_grasp_state_machine.sv @@
// gripper_grasp_state_machine: input register, grasp mode logic and result register
// a control tick passes through the input register, then the result register, which holds its result
// throughput: one transaction per cycle while no stall holds the input register, open/close commands give no result
// a waiting result does not block the input register while the next item is a command
// reset (arst_n low, asynchronous): mode open, count and contact position zero,
// configuration registers at their defaults, both pipeline registers empty
module gripper_grasp_state_machine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  gripgsm_pkg::op_t            op,
	input  logic signed [15:0]          measured_position,
	input  logic signed [15:0]          measured_torque,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [15:0]          position_command,
	output logic signed [15:0]          torque_command,
	output gripgsm_pkg::mode_code_t     mode,
	output logic                        holding,
	output logic                        grasp_failed,
	input  logic                        cfg_we,
	input  gripgsm_pkg::cfg_idx_t       cfg_index,
	input  logic [gripgsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gripgsm_pkg::*;

	// configuration
	logic signed [15:0]    open_position_q;
	logic [STEP_W-1:0]     open_step_q;
	logic signed [15:0]    close_position_q;
	logic [STEP_W-1:0]     close_step_q;
	logic signed [15:0]    open_drive_torque_q;
	logic signed [15:0]    close_drive_torque_q;
	logic signed [15:0]    hold_drive_torque_q;
	logic [THRESH_W-1:0]   contact_torque_q;

	// grasp state
	mode_t                 mode_q;
	logic [COUNT_W-1:0]    contact_count_q;
	logic signed [15:0]    contact_position_q;

	// input register
	logic                  valid_s1;
	op_t                   op_s1;
	logic signed [15:0]    pos_s1;
	logic signed [15:0]    tor_s1;

	// result register
	logic                  out_valid_q;
	logic signed [15:0]    pos_cmd_q;
	logic signed [15:0]    tor_cmd_q;
	mode_t                 out_mode_q;

	logic                  out_free;
	logic                  adv_s1;
	logic                  tick_s1;

	logic signed [16:0]    pos_ext;
	logic signed [16:0]    tor_ext;
	logic [16:0]           tor_mag;
	logic signed [15:0]    open_sum;
	logic signed [15:0]    open_thresh;
	logic signed [15:0]    close_sum;
	logic signed [15:0]    close_limit;
	logic signed [15:0]    hold_sum;
	logic                  over_thresh;
	logic [COUNT_W-1:0]    count_inc;

	mode_t                 mode_d;
	logic [COUNT_W-1:0]    count_d;
	logic signed [15:0]    contact_pos_d;
	logic signed [15:0]    pos_cmd_d;
	logic signed [15:0]    tor_cmd_d;

	assign out_free = !out_valid_q || !out_stall;
	assign tick_s1  = (op_s1 == OP_TICK);
	// commands pass straight through, ticks need room in the result register
	assign adv_s1   = valid_s1 && (!tick_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	assign pos_ext     = 17'(pos_s1);
	assign tor_ext     = 17'(tor_s1);
	assign tor_mag     = tor_ext[16] ? 17'(-tor_ext) : 17'(tor_ext);
	assign over_thresh = tor_mag > {2'b00, contact_torque_q};
	assign count_inc   = (contact_count_q == COUNT_MAX) ? COUNT_MAX : contact_count_q + 3'd1;

	assign open_sum    = sat16(pos_ext + $signed({5'b00000, open_step_q}));
	assign open_thresh = sat16(17'(open_position_q) - IN_PLACE_MARGIN);
	assign close_sum   = sat16(pos_ext - $signed({5'b00000, close_step_q}));
	assign close_limit = sat16(17'(close_position_q) + LIMIT_MARGIN);
	assign hold_sum    = sat16(17'(contact_position_q) - HOLD_PRESS);

	always_comb begin
		mode_d        = mode_q;
		count_d       = contact_count_q;
		contact_pos_d = contact_position_q;
		pos_cmd_d     = pos_s1;
		tor_cmd_d     = '0;
		case (op_s1)
			OP_OPEN: begin
				mode_d        = MODE_OPEN;
				count_d       = '0;
				contact_pos_d = '0;
			end
			OP_CLOSE: begin
				if (mode_q != MODE_CLOSING && mode_q != MODE_HOLD) begin
					mode_d        = MODE_CLOSING;
					count_d       = '0;
					contact_pos_d = '0;
				end
			end
			OP_TICK: begin
				case (mode_q)
					MODE_OPEN: begin
						pos_cmd_d = (open_sum > open_position_q) ? open_position_q : open_sum;
						tor_cmd_d = (pos_s1 > open_thresh) ? 16'sd0 : open_drive_torque_q;
					end
					MODE_CLOSING: begin
						pos_cmd_d = (close_sum < close_position_q) ? close_position_q : close_sum;
						tor_cmd_d = close_drive_torque_q;
						if (pos_s1 <= close_limit) begin
							mode_d = MODE_FAILED;
						end else begin
							count_d = over_thresh ? count_inc : '0;
							if (count_d >= CONTACT_TICKS) begin
								mode_d        = MODE_HOLD;
								contact_pos_d = pos_s1;
							end
						end
					end
					MODE_HOLD: begin
						pos_cmd_d = (hold_sum < close_position_q) ? close_position_q : hold_sum;
						tor_cmd_d = hold_drive_torque_q;
					end
					default: begin
						pos_cmd_d = pos_s1;
						tor_cmd_d = '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_position_q      <= RST_OPEN_POSITION;
			open_step_q          <= RST_OPEN_STEP;
			close_position_q     <= RST_CLOSE_POSITION;
			close_step_q         <= RST_CLOSE_STEP;
			open_drive_torque_q  <= RST_OPEN_DRIVE_TORQUE;
			close_drive_torque_q <= RST_CLOSE_DRIVE_TORQUE;
			hold_drive_torque_q  <= RST_HOLD_DRIVE_TORQUE;
			contact_torque_q     <= RST_CONTACT_TORQUE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_POSITION:      open_position_q      <= cfg_data;
				CFG_OPEN_STEP:          open_step_q          <= cfg_data[STEP_W-1:0];
				CFG_CLOSE_POSITION:     close_position_q     <= cfg_data;
				CFG_CLOSE_STEP:         close_step_q         <= cfg_data[STEP_W-1:0];
				CFG_OPEN_DRIVE_TORQUE:  open_drive_torque_q  <= cfg_data;
				CFG_CLOSE_DRIVE_TORQUE: close_drive_torque_q <= cfg_data;
				CFG_HOLD_DRIVE_TORQUE:  hold_drive_torque_q  <= cfg_data;
				CFG_CONTACT_TORQUE:     contact_torque_q     <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1  <= op;
			pos_s1 <= measured_position;
			tor_s1 <= measured_torque;
		end
	end

	// grasp state, updated as each transaction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q             <= MODE_OPEN;
			contact_count_q    <= '0;
			contact_position_q <= '0;
		end else if (adv_s1) begin
			mode_q             <= mode_d;
			contact_count_q    <= count_d;
			contact_position_q <= contact_pos_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tick_s1) begin
			pos_cmd_q  <= pos_cmd_d;
			tor_cmd_q  <= tor_cmd_d;
			out_mode_q <= mode_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign position_command = pos_cmd_q;
	assign torque_command   = tor_cmd_q;
	assign mode             = mode_code(out_mode_q);
	assign holding          = (out_mode_q == MODE_HOLD);
	assign grasp_failed     = (out_mode_q == MODE_FAILED);

endmodule

@@ src/gripgsm_checker.sv @@
// gripgsm_checker: port-level assertions for gripper_grasp_state_machine
// depends on gripgsm_pkg; bound to the top level at the end of this file
module gripgsm_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [15:0]      position_command,
	input logic signed [15:0]      torque_command,
	input gripgsm_pkg::mode_code_t mode,
	input logic                    holding,
	input logic                    grasp_failed
);
	import gripgsm_pkg::*;

	// a stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position_command)
			&& $stable(torque_command) && $stable(mode))
		else $error("result changed while stalled");

	a_holding_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> holding == (mode == MODE_CODE_HOLD))
		else $error("holding flag disagrees with mode");

	a_failed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> grasp_failed == (mode == MODE_CODE_FAILED))
		else $error("grasp_failed flag disagrees with mode");

	// holding and failed are exclusive
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(holding && grasp_failed))
		else $error("holding and grasp_failed both set");

endmodule

bind gripper_grasp_state_machine gripgsm_checker u_gripgsm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.position_command (position_command),
	.torque_command   (torque_command),
	.mode             (mode),
	.holding          (holding),
	.grasp_failed     (grasp_failed)
);
